>>> src/itad_pkg.sv
// Package for the integer to ASCII digits block.
// Holds the value width, the digit counts, the format codes, character codes
// and the types shared by the front, the queue and the back. No dependencies.
`default_nettype none

package itad_pkg;

   // Value width as carried on the input channel
   localparam int VALUE_BITS = 32;

   // Decimal digits needed for the largest unsigned value: floor(bits*log10(2)) + 1
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int DIGITS     = DEC_DIGITS;
   localparam int BCD_W      = DIGITS * 4;
   localparam int IDX_W      = $clog2(DIGITS);

   // Double-dabble runs two bits per cycle
   localparam int ITERS = (VALUE_BITS + 1) / 2;
   localparam int SHR_W = ITERS * 2;
   localparam int CNT_W = $clog2(ITERS + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Format codes; any other code prints as unsigned decimal
   localparam logic [1:0] CMD_SIGNED_DEC   = 2'd0;
   localparam logic [1:0] CMD_UNSIGNED_DEC = 2'd1;
   localparam logic [1:0] CMD_HEX          = 2'd2;

   // Character codes
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;

   // Classified item as it waits in the queue
   typedef struct packed {
      logic                  neg;
      logic                  hex;
      logic [VALUE_BITS-1:0] mag;
   } item_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

`default_nettype wire

>>> src/itad_if.sv
// Channel interfaces of the integer to ASCII digits block.
// Request channel carries format and value, response channel one character.
// Depends on itad_pkg.
`default_nettype none

interface itad_req_if import itad_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            command;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface itad_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

>>> src/itad_front.sv
// Front of the integer to ASCII digits block: accepts request items,
// splits off the sign and pushes the magnitude into the queue.
// Depends on itad_pkg and itad_if.
`default_nettype none

module itad_front import itad_pkg::*; (
   itad_req_if.sink  req,
   input  qstat_type qstat,
   output logic      push,
   output item_type  item
);

   logic [VALUE_BITS-1:0] raw;

   assign raw       = req.value;
   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;

   always_comb begin
      item.neg = 1'b0;
      item.hex = 1'b0;
      unique case (req.command)
         CMD_SIGNED_DEC: item.neg = raw[VALUE_BITS-1];
         CMD_HEX:        item.hex = 1'b1;
         default:        item.neg = 1'b0;
      endcase
      // two's complement magnitude; the most negative value maps onto itself
      item.mag = item.neg ? (~raw + VALUE_BITS'(1)) : raw;
   end

endmodule

`default_nettype wire

>>> src/itad_queue.sv
// Short queue between the front and the back of the integer to ASCII block.
// Register array with read and write pointers and a fill count.
// Depends on itad_pkg.
`default_nettype none

module itad_queue import itad_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  wr_item,
   input  logic      pop,
   output item_type  rd_item,
   output qstat_type qstat
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign qstat.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.not_empty = (count_ff != '0);
   assign rd_item         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!qstat.full || pop))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.not_empty)
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> src/itad_back.sv
// Back of the integer to ASCII digits block: double-dabble conversion of decimal
// items, leading zero skip, and one character per cycle into the output register
// while its slot is free. Depends on itad_pkg and itad_if.
`default_nettype none

module itad_back import itad_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  qstat_type  qstat,
   output logic       pop,
   itad_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CONV = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [SHR_W-1:0]   shr_ff, shr_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               sign_ff, sign_in;
   logic               hex_ff, hex_in;
   logic               valid_ff, valid_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic               load;
   logic               slot_free;
   logic [3:0]         nib;
   logic [IDX_W-1:0]   lead;

   function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] b);
      logic [BCD_W-1:0] r;
      r = b;
      for (int i = 0; i < DIGITS; i++) begin
         if (r[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = r[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

   assign slot_free = !valid_ff || rsp.ready;
   assign nib       = bcd_ff[4*idx_ff +: 4];

   // highest nonzero digit, zero value gives index zero
   always_comb begin
      lead = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead = IDX_W'(i);
         end
      end
   end

   always_comb begin
      logic [BCD_W-1:0] b;
      logic [SHR_W-1:0] s;
      state_in = state_ff;
      shr_in   = shr_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      sign_in  = sign_ff;
      hex_in   = hex_ff;
      pop      = 1'b0;
      load     = 1'b0;
      char_in  = char_ff;
      last_in  = last_ff;
      b        = bcd_ff;
      s        = shr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (qstat.not_empty) begin
               pop      = 1'b1;
               sign_in  = item.neg;
               hex_in   = item.hex;
               shr_in   = SHR_W'(item.mag);
               // hex needs no conversion: nibbles are the digits
               bcd_in   = item.hex ? BCD_W'(item.mag) : '0;
               cnt_in   = item.hex ? CNT_W'(ITERS) : '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (cnt_ff != CNT_W'(ITERS)) begin
               b = dd_adjust(b);
               b = {b[BCD_W-2:0], s[SHR_W-1]};
               s = {s[SHR_W-2:0], 1'b0};
               b = dd_adjust(b);
               b = {b[BCD_W-2:0], s[SHR_W-1]};
               s = {s[SHR_W-2:0], 1'b0};
               bcd_in = b;
               shr_in = s;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               idx_in   = lead;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               load = 1'b1;
               if (sign_ff) begin
                  char_in = CHAR_MINUS;
                  last_in = 1'b0;
                  sign_in = 1'b0;
               end else begin
                  char_in = (nib < 4'd10) ? (CHAR_ZERO + 8'(nib))
                                          : (CHAR_A + 8'(nib) - 8'd10);
                  last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         sign_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         sign_ff  <= sign_in;
      end
   end

   always_ff @(posedge clock) begin
      shr_ff  <= shr_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      hex_ff  <= hex_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.character = char_ff;
   assign rsp.last      = last_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV) |-> (cnt_ff <= CNT_W'(ITERS)))
      else $error("conversion count past end");
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && load && !sign_ff && !hex_ff) |-> (nib < 4'd10))
      else $error("decimal digit out of range");
   a_idle_no_sign: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sign_ff)
      else $error("sign pending while idle");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == S_CONV))
      else $error("pop did not start a conversion");
`endif

endmodule

`default_nettype wire

>>> src/integer_to_ascii_digits.sv
// Integer to ASCII digits: value and format in, one or more characters per item out.
// An accepted item is written into the queue at once, and the back pops it when idle;
// decimal conversion takes 16 double-dabble steps of two bits, hex skips these steps.
// The queue keeps taking items while the back works; the back, with one shared double-dabble
// unit, handles one item at a time and emits N = 1..11 characters, one per free output slot.
// Reset: synchronous, active high; clears queue pointers, back state and output valid.
`default_nettype none

module integer_to_ascii_digits import itad_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   itad_req_if.sink   req_chan,
   itad_rsp_if.source rsp_chan
);

   // Classified item handed from front to queue and from queue to back
   item_type  push_item;
   item_type  pop_item;
   qstat_type qstat;
   logic      push;
   logic      pop;

   // Front: take the item when the queue has room, split sign from magnitude
   itad_front u_front (
      .req   (req_chan),
      .qstat (qstat),
      .push  (push),
      .item  (push_item)
   );

   // Queue: hold classified items so intake keeps going while the back emits text
   itad_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (push_item),
      .pop     (pop),
      .rd_item (pop_item),
      .qstat   (qstat)
   );

   // Back: convert to digits, drop leading zeros, advance one character per free slot
   itad_back u_back (
      .clock (clock),
      .reset (reset),
      .item  (pop_item),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire
